// File: rtl/core/box_collision_table_macros.svh
// assertion helpers for the collision table
`ifndef BOX_COLLISION_TABLE_MACROS_SVH
`define BOX_COLLISION_TABLE_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define BCT_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("collision table check failed");

// condition never holds
`define BCT_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("collision table check failed");

`else

`define BCT_ASSERT_IMPLIES(lbl, ante, cons)
`define BCT_ASSERT_NEVER(lbl, cond)

`endif

`endif

// File: rtl/core/bct_pkg.sv
package bct_pkg;

	// table depth default
	localparam int SLOTS_DEF = 32;

	// fixed field widths
	localparam int SLOT_W   = 5;
	localparam int MODE_W   = 3;
	localparam int KIND_W   = 2;
	localparam int TYPE_W   = 4;
	localparam int MASK_LO_W = 45;
	localparam int MASK_HI_W = 36;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = MASK_LO_W;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SET   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MARK  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PURGE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ERASE = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SWEEP = 3'd6;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_HIT  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DONE = 2'd3;

	// box types; erase keeps player and god
	localparam logic [TYPE_W-1:0] TYPE_PLAYER = 4'd1;
	localparam logic [TYPE_W-1:0] TYPE_GOD    = 4'd7;
	localparam logic [TYPE_W-1:0] TYPE_LAST   = 4'd8;
	localparam logic [TYPE_W-1:0] TYPE_ROW_HI = 4'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAIR_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAIR_HIGH = 1'b1;

	// input word
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [SLOT_W-1:0]  slot;
		logic signed [15:0] left_x;
		logic signed [15:0] top_y;
		logic [11:0]        box_width;
		logic [11:0]        box_height;
		logic [TYPE_W-1:0]  box_type;
		logic               notify;
	} cmd_t;

	// result word
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] receiver_slot;
		logic [SLOT_W-1:0] other_slot;
		logic              last;
	} res_t;

	// table entry, geometry and attributes written separately
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [11:0]        w;
		logic [11:0]        h;
	} geo_t;

	typedef struct packed {
		logic [TYPE_W-1:0] box_type;
		logic              notify;
	} attr_t;

	typedef struct packed {
		geo_t  geo;
		attr_t attr;
	} entry_t;

	// table write enables
	typedef struct packed {
		logic geo;
		logic attr;
	} wr_en_t;

	// hit decision of the compare unit
	typedef struct packed {
		logic to_row;
		logic to_cand;
	} hit_t;

	function automatic entry_t to_entry(cmd_t c);
		entry_t e;
		e.geo.x         = c.left_x;
		e.geo.y         = c.top_y;
		e.geo.w         = c.box_width;
		e.geo.h         = c.box_height;
		e.attr.box_type = c.box_type;
		e.attr.notify   = c.notify;
		return e;
	endfunction

	function automatic res_t mk_res(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] recv,
			logic [SLOT_W-1:0] other, logic last);
		res_t r;
		r.kind          = kind;
		r.receiver_slot = recv;
		r.other_slot    = other;
		r.last          = last;
		return r;
	endfunction

	// may a box of type row be hit by a box of type other
	function automatic logic pair_allowed(logic [MASK_LO_W-1:0] lo, logic [MASK_HI_W-1:0] hi,
			logic [TYPE_W-1:0] row, logic [TYPE_W-1:0] other);
		logic [5:0] idx;
		logic       ok;
		ok = 1'b0;
		if (row <= TYPE_LAST && other <= TYPE_LAST) begin
			if (row < TYPE_ROW_HI) begin
				idx = 6'(row) * 6'd9 + 6'(other);
				ok  = lo[idx];
			end else begin
				idx = 6'(row - TYPE_ROW_HI) * 6'd9 + 6'(other);
				ok  = hi[idx];
			end
		end
		return ok;
	endfunction

endpackage

// File: rtl/core/bct_table.sv
module bct_table #(
	parameter int SLOTS = bct_pkg::SLOTS_DEF
) (
	input  logic                  clk,
	input  bct_pkg::wr_en_t       we,
	input  logic [$clog2(SLOTS)-1:0] waddr,
	input  bct_pkg::entry_t       wdata,
	input  logic [$clog2(SLOTS)-1:0] raddr,
	output bct_pkg::entry_t       rdata
);

	bct_pkg::geo_t  geo_mem  [SLOTS];
	bct_pkg::attr_t attr_mem [SLOTS];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we.geo) begin
			geo_mem[waddr] <= wdata.geo;
		end
		if (we.attr) begin
			attr_mem[waddr] <= wdata.attr;
		end
		rdata.geo  <= geo_mem[raddr];
		rdata.attr <= attr_mem[raddr];
	end

endmodule

// File: rtl/core/bct_hit_unit.sv
module bct_hit_unit (
	input  bct_pkg::entry_t                     row,
	input  bct_pkg::entry_t                     cand,
	input  logic                                cand_valid,
	input  logic [bct_pkg::MASK_LO_W-1:0]       mask_lo,
	input  logic [bct_pkg::MASK_HI_W-1:0]       mask_hi,
	output bct_pkg::hit_t                       hit
);

	logic signed [17:0] ax, ay, bx, by;
	logic signed [17:0] ax_end, ay_end, bx_end, by_end;
	logic               overlap;

	// edges widened so the far edge cannot wrap
	assign ax     = 18'(row.geo.x);
	assign ay     = 18'(row.geo.y);
	assign bx     = 18'(cand.geo.x);
	assign by     = 18'(cand.geo.y);
	assign ax_end = ax + $signed({6'b0, row.geo.w});
	assign ay_end = ay + $signed({6'b0, row.geo.h});
	assign bx_end = bx + $signed({6'b0, cand.geo.w});
	assign by_end = by + $signed({6'b0, cand.geo.h});

	// strict overlap, touching edges do not count
	assign overlap = cand_valid && (by_end > ay) && (by < ay_end)
		&& (bx_end > ax) && (bx < ax_end);

	// hit to each side allowed by the matrix and asking for reports
	assign hit.to_row = overlap && row.attr.notify
		&& bct_pkg::pair_allowed(mask_lo, mask_hi, row.attr.box_type, cand.attr.box_type);
	assign hit.to_cand = overlap && cand.attr.notify
		&& bct_pkg::pair_allowed(mask_lo, mask_hi, cand.attr.box_type, row.attr.box_type);

endmodule

// File: rtl/core/box_collision_table.sv
// channel  | direction | handshake              | word
// command  | in        | start high, busy low   | cmd (mode, slot, box, type, notify)
// result   | out       | strobe, one cycle      | res (kind, slots, last)
// config   | in        | cfg_we                 | cfg_index, cfg_data
//
// set, mark, purge, clear, no-op and empty-slot sweep words answer in the cycle after
// acceptance without raising busy. add scans valid bits one slot a cycle. erase reads one
// table entry a cycle. a row sweep reads the row entry, then each later slot in turn
// (none when the row is the last slot), with an extra state for each pair that hits both
// ways, paced by the single table read port and the one overlap compare unit.
// reset clears the valid bits and the pair masks; results cannot be stalled.
`include "box_collision_table_macros.svh"

module box_collision_table #(
	parameter int SLOTS = bct_pkg::SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  bct_pkg::cmd_t                     cmd,
	output logic                              strobe,
	output bct_pkg::res_t                     res,
	input  logic                              cfg_we,
	input  logic [bct_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bct_pkg::CFG_W-1:0]         cfg_data
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
	localparam logic [bct_pkg::SLOT_W:0] SLOTS_X = (bct_pkg::SLOT_W + 1)'(SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_ERASE,
		ST_ROW,
		ST_SCAN,
		ST_HIT2,
		ST_DONE
	} state_t;

	state_t                         state_q, state_d;
	logic [IW-1:0]                  k_q, k_d, k_inc;
	logic [SLOTS-1:0]               valid_q, valid_d;
	logic                           marked_q [SLOTS];
	logic                           strobe_q, emit;
	bct_pkg::res_t                  res_q, res_d;
	bct_pkg::cmd_t                  cmd_q;
	bct_pkg::entry_t                row_q;
	logic [bct_pkg::MASK_LO_W-1:0]  mask_lo_q;
	logic [bct_pkg::MASK_HI_W-1:0]  mask_hi_q;

	bct_pkg::wr_en_t                we;
	logic [IW-1:0]                  waddr, raddr;
	bct_pkg::entry_t                wdata, rdata;
	bct_pkg::hit_t                  hit;

	logic                           accept, in_range, s_ok;
	logic [IW-1:0]                  s_idx, sq_idx;
	logic                           mark_set, mark_clr;
	logic [IW-1:0]                  mark_addr;

	assign accept   = start && (state_q == ST_IDLE);
	assign s_idx    = cmd.slot[IW-1:0];
	assign sq_idx   = cmd_q.slot[IW-1:0];
	assign in_range = {1'b0, cmd.slot} < SLOTS_X;
	assign s_ok     = in_range && valid_q[s_idx];
	assign k_inc    = (k_q == LAST_IDX) ? '0 : IW'(k_q + 1'b1);

	// sequencer decisions
	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		valid_d   = valid_q;
		emit      = 1'b0;
		res_d     = res_q;
		we        = '0;
		waddr     = k_q;
		wdata     = bct_pkg::to_entry(cmd_q);
		raddr     = k_q;
		mark_set  = 1'b0;
		mark_clr  = 1'b0;
		mark_addr = k_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.mode)
						bct_pkg::MODE_ADD: begin
							k_d     = '0;
							state_d = ST_FIND;
						end
						bct_pkg::MODE_SET: begin
							we.geo = s_ok;
							waddr  = s_idx;
							wdata  = bct_pkg::to_entry(cmd);
							emit   = 1'b1;
							res_d  = bct_pkg::mk_res(bct_pkg::KIND_ACK, cmd.slot, '0, 1'b1);
						end
						bct_pkg::MODE_MARK: begin
							mark_set  = s_ok;
							mark_addr = s_idx;
							emit      = 1'b1;
							res_d     = bct_pkg::mk_res(bct_pkg::KIND_ACK, cmd.slot, '0, 1'b1);
						end
						bct_pkg::MODE_PURGE: begin
							for (int i = 0; i < SLOTS; i++) begin
								valid_d[i] = valid_q[i] && !marked_q[i];
							end
							emit  = 1'b1;
							res_d = bct_pkg::mk_res(bct_pkg::KIND_ACK, '0, '0, 1'b1);
						end
						bct_pkg::MODE_ERASE: begin
							k_d     = '0;
							raddr   = '0;
							state_d = ST_ERASE;
						end
						bct_pkg::MODE_CLEAR: begin
							valid_d = '0;
							emit    = 1'b1;
							res_d   = bct_pkg::mk_res(bct_pkg::KIND_ACK, '0, '0, 1'b1);
						end
						bct_pkg::MODE_SWEEP: begin
							if (s_ok) begin
								raddr   = s_idx;
								state_d = ST_ROW;
							end else begin
								emit  = 1'b1;
								res_d = bct_pkg::mk_res(bct_pkg::KIND_DONE, cmd.slot, '0, 1'b1);
							end
						end
						default: begin
							emit  = 1'b1;
							res_d = bct_pkg::mk_res(bct_pkg::KIND_ACK, '0, '0, 1'b1);
						end
					endcase
				end
			end
			ST_FIND: begin
				if (!valid_q[k_q]) begin
					we         = '{geo: 1'b1, attr: 1'b1};
					valid_d[k_q] = 1'b1;
					mark_clr   = 1'b1;
					emit       = 1'b1;
					res_d      = bct_pkg::mk_res(bct_pkg::KIND_ACK,
						bct_pkg::SLOT_W'(k_q), '0, 1'b1);
					state_d    = ST_IDLE;
				end else if (k_q == LAST_IDX) begin
					emit    = 1'b1;
					res_d   = bct_pkg::mk_res(bct_pkg::KIND_FULL, '0, '0, 1'b1);
					state_d = ST_IDLE;
				end else begin
					k_d = k_inc;
				end
			end
			ST_ERASE: begin
				// read data holds entry k
				if (valid_q[k_q] && rdata.attr.box_type != bct_pkg::TYPE_PLAYER
						&& rdata.attr.box_type != bct_pkg::TYPE_GOD) begin
					valid_d[k_q] = 1'b0;
				end
				raddr = k_inc;
				k_d   = k_inc;
				if (k_q == LAST_IDX) begin
					emit    = 1'b1;
					res_d   = bct_pkg::mk_res(bct_pkg::KIND_ACK, '0, '0, 1'b1);
					state_d = ST_IDLE;
				end
			end
			ST_ROW: begin
				// row entry arrives, start the first candidate read
				if (sq_idx == LAST_IDX) begin
					emit    = 1'b1;
					res_d   = bct_pkg::mk_res(bct_pkg::KIND_DONE, cmd_q.slot, '0, 1'b1);
					state_d = ST_IDLE;
				end else begin
					k_d     = IW'(sq_idx + 1'b1);
					raddr   = IW'(sq_idx + 1'b1);
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit.to_row) begin
					emit  = 1'b1;
					res_d = bct_pkg::mk_res(bct_pkg::KIND_HIT, cmd_q.slot,
						bct_pkg::SLOT_W'(k_q), 1'b0);
				end else if (hit.to_cand) begin
					emit  = 1'b1;
					res_d = bct_pkg::mk_res(bct_pkg::KIND_HIT, bct_pkg::SLOT_W'(k_q),
						cmd_q.slot, 1'b0);
				end
				if (hit.to_row && hit.to_cand) begin
					state_d = ST_HIT2;
				end else if (k_q == LAST_IDX) begin
					state_d = ST_DONE;
				end else begin
					k_d   = k_inc;
					raddr = k_inc;
				end
			end
			ST_HIT2: begin
				emit  = 1'b1;
				res_d = bct_pkg::mk_res(bct_pkg::KIND_HIT, bct_pkg::SLOT_W'(k_q),
					cmd_q.slot, 1'b0);
				if (k_q == LAST_IDX) begin
					state_d = ST_DONE;
				end else begin
					k_d     = k_inc;
					raddr   = k_inc;
					state_d = ST_SCAN;
				end
			end
			ST_DONE: begin
				emit    = 1'b1;
				res_d   = bct_pkg::mk_res(bct_pkg::KIND_DONE, cmd_q.slot, '0, 1'b1);
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, valid bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			valid_q  <= '0;
			strobe_q <= 1'b0;
			res_q    <= '0;
		end else begin
			state_q  <= state_d;
			k_q      <= k_d;
			valid_q  <= valid_d;
			strobe_q <= emit;
			res_q    <= res_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_ROW) begin
			row_q <= rdata;
		end
		if (mark_set) begin
			marked_q[mark_addr] <= 1'b1;
		end else if (mark_clr) begin
			marked_q[mark_addr] <= 1'b0;
		end
	end

	// pair masks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_lo_q <= '0;
			mask_hi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bct_pkg::CFG_PAIR_LOW:  mask_lo_q <= cfg_data;
				bct_pkg::CFG_PAIR_HIGH: mask_hi_q <= cfg_data[bct_pkg::MASK_HI_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bct_table #(
		.SLOTS (SLOTS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	bct_hit_unit u_hit (
		.row        (row_q),
		.cand       (rdata),
		.cand_valid (valid_q[k_q]),
		.mask_lo    (mask_lo_q),
		.mask_hi    (mask_hi_q),
		.hit        (hit)
	);

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign res    = res_q;

	// hits only come out mid-sweep and are never the final word
	`BCT_ASSERT_IMPLIES(a_hit_in_sweep, strobe && res.kind == bct_pkg::KIND_HIT, busy && !res.last)
	// a full answer means no slot was free
	`BCT_ASSERT_IMPLIES(a_full_all_valid, strobe && res.kind == bct_pkg::KIND_FULL, &valid_q)
	// a multi-cycle item never starts with a leftover result
	`BCT_ASSERT_NEVER(a_rise_no_strobe, $rose(busy) && strobe)

endmodule
